// ----- hdl/gds_pkg.sv -----
// Shared types, constants and helpers for the Gregorian date stepper.
// Used by gds_leap, gds_alu and gregorian_date_stepper_core; depends on nothing.
`default_nettype none

package gds_pkg;

    // Year register width and field widths
    localparam int YEAR_WIDTH  = 16;
    localparam int LD_YEAR_W   = 16;
    localparam int YEAR_OUT_W  = 16;
    localparam int LOAD_W      = (YEAR_WIDTH > LD_YEAR_W) ? YEAR_WIDTH : LD_YEAR_W;
    localparam int ACTION_W    = 2;
    localparam int LD_MONTH_W  = 8;
    localparam int DAY_W       = 13;
    localparam int MONTH_W     = 9;   // holds the load month - 1 before it is brought into range
    localparam int MONTH_OUT_W = 4;
    localparam int DAY_OUT_W   = 5;
    localparam int MLEN_W      = 5;

    // Stream word layout
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;
    localparam int S_USER_W  = ACTION_W;
    localparam int M_USER_W  = 1;
    localparam int M_PAD_W   = M_TDATA_W - MONTH_OUT_W - DAY_OUT_W - YEAR_OUT_W;

    // Action codes carried in s_tuser
    typedef enum logic [ACTION_W-1:0] {
        ACT_SET = 2'd0,
        ACT_INC = 2'd1,
        ACT_DEC = 2'd2
    } gds_action_t;

    // Operations of the shared day adder
    typedef enum logic [1:0] {
        ALU_INC    = 2'd0,
        ALU_DEC    = 2'd1,
        ALU_BORROW = 2'd2,
        ALU_CARRY  = 2'd3
    } gds_alu_op_t;

    typedef struct packed {
        gds_alu_op_t op;
        logic        year_up;
    } gds_alu_ctrl_t;

    typedef struct packed {
        logic                        day_le0;
        logic                        day_over;
        logic signed [DAY_W-1:0]     day_res;
        logic        [YEAR_WIDTH-1:0] year_res;
        logic                        year_wrap;
    } gds_alu_stat_t;

    // Month indexes (0-based) and month arithmetic constants
    localparam logic [3:0] MONTH_JAN = 4'd0;
    localparam logic [3:0] MONTH_FEB = 4'd1;
    localparam logic [3:0] MONTH_DEC = 4'd11;
    localparam logic signed [MONTH_W-1:0] MONTH_SPAN = 9'sd12;
    localparam logic signed [MONTH_W-1:0] MONTH_LAST = 9'sd11;
    localparam logic signed [MONTH_W-1:0] MONTH_ONE  = 9'sd1;
    localparam logic signed [MONTH_W-1:0] MONTH_ZERO = 9'sd0;

    localparam logic [MLEN_W-1:0] LEAP_FEB_LEN = 5'd29;
    localparam logic [MLEN_W-1:0] MLEN_TAB [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Year limits for wrap detection
    localparam logic [YEAR_WIDTH-1:0] YEAR_MAX = {1'b0, {(YEAR_WIDTH-1){1'b1}}};
    localparam logic [YEAR_WIDTH-1:0] YEAR_MIN = {1'b1, {(YEAR_WIDTH-1){1'b0}}};

    // Divide-by-25 through a reciprocal: floor(a * RECIP25 >> SHIFT25) == a / 25
    localparam int SHIFT25 = YEAR_WIDTH + 5;
    localparam int K_W     = YEAR_WIDTH + 1;
    localparam int PROD_W  = YEAR_WIDTH + K_W;
    localparam logic [63:0] RECIP25_FULL = ((64'd1 << SHIFT25) / 64'd25) + 64'd1;
    localparam logic [K_W-1:0] RECIP25   = RECIP25_FULL[K_W-1:0];
    localparam logic [YEAR_WIDTH-1:0] DIV25 = YEAR_WIDTH'(25);

    // Leap-aware month length, m is a 0-based month
    function automatic logic [MLEN_W-1:0] month_len(input logic [3:0] m, input logic leap);
        logic [MLEN_W-1:0] len;
        if (m == MONTH_FEB && leap) begin
            len = LEAP_FEB_LEN;
        end else if (m <= MONTH_DEC) begin
            len = MLEN_TAB[m];
        end else begin
            len = MLEN_TAB[MONTH_JAN];
        end
        return len;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/gds_leap.sv -----
// Two-stage pipelined leap-year test that follows the year register.
// Depends on gds_pkg (widths, reciprocal constant for divide by 25).
`default_nettype none

module gds_leap (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [gds_pkg::YEAR_WIDTH-1:0]  year_i,
    output logic                                 leap_o
);

    logic [gds_pkg::YEAR_WIDTH-1:0] abs_val;
    logic [gds_pkg::YEAR_WIDTH-1:0] abs_reg;
    logic [gds_pkg::PROD_W-1:0]     prod_next;
    logic [gds_pkg::PROD_W-1:0]     prod_reg;
    logic                           div4_reg;
    logic                           div16_reg;
    logic [gds_pkg::YEAR_WIDTH-1:0] quot;
    logic [gds_pkg::YEAR_WIDTH-1:0] back;
    logic                           div25;
    logic                           leap_next;
    logic                           leap_reg;

    // Stage 1: magnitude and reciprocal multiply
    always_comb begin
        abs_val   = year_i[gds_pkg::YEAR_WIDTH-1] ? (~year_i + 1'b1) : year_i;
        prod_next = gds_pkg::PROD_W'(abs_val) * gds_pkg::PROD_W'(gds_pkg::RECIP25);
    end

    // Stage 2: remainder check, then the century rule
    always_comb begin
        quot      = gds_pkg::YEAR_WIDTH'(prod_reg >> gds_pkg::SHIFT25);
        back      = quot * gds_pkg::DIV25;
        div25     = (back == abs_reg);
        leap_next = div4_reg && (!div25 || div16_reg);
    end

    // Reset values match year 0, which is a leap year
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            abs_reg   <= '0;
            prod_reg  <= '0;
            div4_reg  <= 1'b1;
            div16_reg <= 1'b1;
            leap_reg  <= 1'b1;
        end else begin
            abs_reg   <= abs_val;
            prod_reg  <= prod_next;
            div4_reg  <= (year_i[1:0] == 2'b00);
            div16_reg <= (year_i[3:0] == 4'b0000);
            leap_reg  <= leap_next;
        end
    end

    assign leap_o = leap_reg;

endmodule

`default_nettype wire

// ----- hdl/gds_alu.sv -----
// Shared day adder/comparator and year stepper used by the idle, month and walk steps.
// Depends on gds_pkg (ALU control/status structs, month length table).
`default_nettype none

module gds_alu (
    input  wire logic signed [gds_pkg::DAY_W-1:0]      day_i,
    input  wire logic        [3:0]                     month_i,
    input  wire logic                                  leap_i,
    input  wire logic        [gds_pkg::YEAR_WIDTH-1:0] year_i,
    input  wire gds_pkg::gds_alu_ctrl_t                ctrl_i,
    output gds_pkg::gds_alu_stat_t                     stat_o
);

    logic [gds_pkg::MLEN_W-1:0] mlen_cur;
    logic [gds_pkg::MLEN_W-1:0] mlen_prev;
    logic [3:0]                 month_prev;
    logic [gds_pkg::DAY_W-1:0]  opnd;
    logic                       sub;

    // Lengths of this month and of the one before it
    always_comb begin
        month_prev = (month_i == gds_pkg::MONTH_JAN) ? gds_pkg::MONTH_DEC : (month_i - 4'd1);
        mlen_cur   = gds_pkg::month_len(month_i, leap_i);
        mlen_prev  = gds_pkg::month_len(month_prev, leap_i);
    end

    // Operand select for the single add/subtract
    always_comb begin
        case (ctrl_i.op)
            gds_pkg::ALU_INC: begin
                opnd = gds_pkg::DAY_W'(1);
                sub  = 1'b0;
            end
            gds_pkg::ALU_DEC: begin
                opnd = gds_pkg::DAY_W'(1);
                sub  = 1'b1;
            end
            gds_pkg::ALU_BORROW: begin
                opnd = gds_pkg::DAY_W'(mlen_prev);
                sub  = 1'b0;
            end
            default: begin
                opnd = gds_pkg::DAY_W'(mlen_cur);
                sub  = 1'b1;
            end
        endcase
    end

    // Day add and range compare, year step with wrap flag
    always_comb begin
        stat_o.day_res  = day_i + $signed(sub ? ~opnd : opnd) + $signed(gds_pkg::DAY_W'(sub));
        stat_o.day_le0  = day_i[gds_pkg::DAY_W-1] || (day_i == '0);
        stat_o.day_over = !day_i[gds_pkg::DAY_W-1]
                          && (gds_pkg::DAY_W'(day_i) > gds_pkg::DAY_W'(mlen_cur));
        if (ctrl_i.year_up) begin
            stat_o.year_res  = year_i + gds_pkg::YEAR_WIDTH'(1);
            stat_o.year_wrap = (year_i == gds_pkg::YEAR_MAX);
        end else begin
            stat_o.year_res  = year_i - gds_pkg::YEAR_WIDTH'(1);
            stat_o.year_wrap = (year_i == gds_pkg::YEAR_MIN);
        end
    end

endmodule

`default_nettype wire

// ----- hdl/gregorian_date_stepper_core.sv -----
// Gregorian date stepper: keeps a date and applies set / +1 day / -1 day words.
//
// Input channel s_*: one word per action. s_tuser holds the action code (set,
// increment, decrement); s_tdata holds the load month, day and year. Output
// channel m_*: one word per action with the normalized date and a year-wrap flag.
// A sequencer drives one shared day adder and year stepper; a two-stage leap
// test tracks the year register. s_tready is high only while no word is in work.
// Increment/decrement: the day is stepped on acceptance; the walk step then
// moves the month while the day is out of range (via the wait step when the
// year changes) and the word is delivered. A new word is taken only once the
// last has entered the output register. Set: one month step per year of month
// carry, a wait step, then one walk step per month walked by the day adder
// (plus a wait per year crossed), a range check, delivery; the walk dominates.
// Results sit in an output register; while the receiver stalls, the next word
// may still be accepted and worked on, and it waits at delivery until the
// register frees up. Reset (aresetn low, synchronous) gives 1 January year 0,
// an empty output register and an idle sequencer.
// Month-length table and leap rule are proleptic Gregorian with signed years.
`default_nettype none

module gregorian_date_stepper_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [7:0] ld_month, [20:8] ld_day, [36:21] ld_year, [39:37] zero
    input  wire logic [gds_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] action
    input  wire logic [gds_pkg::S_USER_W-1:0]    s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [3:0] month_out, [8:4] day_out, [24:9] year_out, [31:25] zero
    output logic [gds_pkg::M_TDATA_W-1:0]        m_tdata,
    // [0] year_wrapped
    output logic [gds_pkg::M_USER_W-1:0]         m_tuser
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MONTH,
        ST_WAIT,
        ST_WALK,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    logic signed [gds_pkg::MONTH_W-1:0]    month_reg, month_next;
    logic signed [gds_pkg::DAY_W-1:0]      day_reg, day_next;
    logic        [gds_pkg::YEAR_WIDTH-1:0] year_reg, year_next;
    logic                                  wrap_reg, wrap_next;
    logic                                  m_tvalid_reg, m_tvalid_next;
    logic        [gds_pkg::M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic        [gds_pkg::M_USER_W-1:0]   m_tuser_reg, m_tuser_next;

    logic                                   s_accept;
    gds_pkg::gds_action_t                   in_action;
    logic signed [gds_pkg::LD_MONTH_W-1:0]  in_month;
    logic signed [gds_pkg::DAY_W-1:0]       in_day;
    logic signed [gds_pkg::LD_YEAR_W-1:0]   in_year;
    logic signed [gds_pkg::LOAD_W-1:0]      year_wide;
    logic        [gds_pkg::YEAR_WIDTH-1:0]  year_fit;
    logic                                   load_wrap;
    logic        [3:0]                      month_idx;
    logic                                   day_nonpos;
    logic                                   leap;
    gds_pkg::gds_alu_ctrl_t                 alu_ctrl;
    gds_pkg::gds_alu_stat_t                 alu_stat;
    logic        [gds_pkg::MONTH_OUT_W-1:0] month_out;

    // Word unpack and year fit on load
    always_comb begin
        in_action = gds_pkg::gds_action_t'(s_tuser);
        in_month  = s_tdata[7:0];
        in_day    = s_tdata[20:8];
        in_year   = s_tdata[36:21];
        year_wide = gds_pkg::LOAD_W'(in_year);
        year_fit  = gds_pkg::YEAR_WIDTH'(year_wide);
        load_wrap = (gds_pkg::LOAD_W'($signed(year_fit)) != year_wide);
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign month_idx  = month_reg[3:0];
    assign day_nonpos = day_reg[gds_pkg::DAY_W-1] || (day_reg == '0);

    gds_leap u_leap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .year_i  (year_reg),
        .leap_o  (leap)
    );

    // Shared unit control
    always_comb begin
        alu_ctrl.op      = gds_pkg::ALU_INC;
        alu_ctrl.year_up = 1'b1;
        unique case (state_reg)
            ST_IDLE: begin
                alu_ctrl.op = (in_action == gds_pkg::ACT_DEC) ? gds_pkg::ALU_DEC
                                                             : gds_pkg::ALU_INC;
            end
            ST_MONTH: begin
                alu_ctrl.year_up = !month_reg[gds_pkg::MONTH_W-1];
            end
            ST_WALK: begin
                alu_ctrl.op      = day_nonpos ? gds_pkg::ALU_BORROW : gds_pkg::ALU_CARRY;
                alu_ctrl.year_up = !day_nonpos;
            end
            default: begin
                alu_ctrl.op = gds_pkg::ALU_INC;
            end
        endcase
    end

    gds_alu u_alu (
        .day_i   (day_reg),
        .month_i (month_idx),
        .leap_i  (leap),
        .year_i  (year_reg),
        .ctrl_i  (alu_ctrl),
        .stat_o  (alu_stat)
    );

    assign month_out = month_idx + 4'd1;

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        month_next    = month_reg;
        day_next      = day_reg;
        year_next     = year_reg;
        wrap_next     = wrap_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    wrap_next = 1'b0;
                    unique case (in_action)
                        gds_pkg::ACT_SET: begin
                            month_next = gds_pkg::MONTH_W'(in_month) - gds_pkg::MONTH_ONE;
                            day_next   = in_day;
                            year_next  = year_fit;
                            wrap_next  = load_wrap;
                            state_next = ST_MONTH;
                        end
                        gds_pkg::ACT_INC, gds_pkg::ACT_DEC: begin
                            day_next   = alu_stat.day_res;
                            state_next = ST_WALK;
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            // Bring the month into 0..11, one year per step
            ST_MONTH: begin
                if (month_reg < gds_pkg::MONTH_ZERO) begin
                    month_next = month_reg + gds_pkg::MONTH_SPAN;
                    year_next  = alu_stat.year_res;
                    wrap_next  = wrap_reg || alu_stat.year_wrap;
                end else if (month_reg > gds_pkg::MONTH_LAST) begin
                    month_next = month_reg - gds_pkg::MONTH_SPAN;
                    year_next  = alu_stat.year_res;
                    wrap_next  = wrap_reg || alu_stat.year_wrap;
                end else begin
                    state_next = ST_WAIT;
                end
            end
            // Let the leap pipeline catch up with a new year
            ST_WAIT: begin
                state_next = ST_WALK;
            end
            // Walk the day one month per step
            ST_WALK: begin
                if (alu_stat.day_le0) begin
                    day_next = alu_stat.day_res;
                    if (month_idx == gds_pkg::MONTH_JAN) begin
                        month_next = gds_pkg::MONTH_LAST;
                        year_next  = alu_stat.year_res;
                        wrap_next  = wrap_reg || alu_stat.year_wrap;
                        state_next = ST_WAIT;
                    end else begin
                        month_next = month_reg - gds_pkg::MONTH_ONE;
                    end
                end else if (alu_stat.day_over) begin
                    day_next = alu_stat.day_res;
                    if (month_idx == gds_pkg::MONTH_DEC) begin
                        month_next = gds_pkg::MONTH_ZERO;
                        year_next  = alu_stat.year_res;
                        wrap_next  = wrap_reg || alu_stat.year_wrap;
                        state_next = ST_WAIT;
                    end else begin
                        month_next = month_reg + gds_pkg::MONTH_ONE;
                    end
                end else begin
                    state_next = ST_FINISH;
                end
            end
            // Deliver once the output register is free
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{gds_pkg::M_PAD_W{1'b0}},
                                     gds_pkg::YEAR_OUT_W'(year_reg),
                                     day_reg[gds_pkg::DAY_OUT_W-1:0],
                                     month_out};
                    m_tuser_next  = wrap_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            month_reg    <= gds_pkg::MONTH_ZERO;
            day_reg      <= gds_pkg::DAY_W'(1);
            year_reg     <= '0;
            wrap_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            month_reg    <= month_next;
            day_reg      <= day_next;
            year_reg     <= year_next;
            wrap_reg     <= wrap_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Month index is in range whenever days are walked
    a_walk_month: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (!month_reg[gds_pkg::MONTH_W-1] &&
                                    month_reg <= gds_pkg::MONTH_LAST))
        else $error("month out of range during day walk");

    // Delivered month is 1..12 and delivered day is nonzero
    a_out_date: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tdata_reg[3:0] != 4'd0 && m_tdata_reg[3:0] <= 4'd12 &&
                          m_tdata_reg[8:4] != 5'd0))
        else $error("output date out of range");

    // A finished word reaches the output register and frees the input
    a_deliver: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && (!m_tvalid_reg || m_tready))
            |=> (m_tvalid_reg && state_reg == ST_IDLE))
        else $error("finished word not delivered");

    // Day ticks go straight to the walk step
    a_tick_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (in_action == gds_pkg::ACT_INC || in_action == gds_pkg::ACT_DEC))
            |=> (state_reg == ST_WALK))
        else $error("day tick did not start walk");

endmodule

`default_nettype wire

// ----- tb/gregorian_date_stepper_core_tb.sv -----
// Testbench for gregorian_date_stepper_core: directed table, then random set/step runs,
// checked against typed-in dates or a date predictor. Depends on gds_pkg and the core RTL.
`timescale 1ns / 1ps

module gregorian_date_stepper_core_tb;

    // Unused action code: the block holds its date
    localparam logic [gds_pkg::ACTION_W-1:0] ACT_NONE = 2'd3;
    localparam int RANDOM_ITEMS = 1650;
    localparam int DRAIN_CYCLES = 250;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [gds_pkg::MONTH_OUT_W-1:0] month;
        logic [gds_pkg::DAY_OUT_W-1:0]   day;
        logic [gds_pkg::YEAR_OUT_W-1:0]  year;
        logic                            wrap;
    } date_word_t;

    typedef struct packed {
        logic [gds_pkg::ACTION_W-1:0]   act;
        logic [gds_pkg::LD_MONTH_W-1:0] month;
        logic [gds_pkg::DAY_W-1:0]      day;
        logic [gds_pkg::LD_YEAR_W-1:0]  year;
        logic                           known;   // expected date typed in below
        date_word_t                     want;
    } stim_row_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [gds_pkg::S_TDATA_W-1:0]    s_tdata;
    logic [gds_pkg::S_USER_W-1:0]     s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [gds_pkg::M_TDATA_W-1:0]    m_tdata;
    logic [gds_pkg::M_USER_W-1:0]     m_tuser;

    gregorian_date_stepper_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    date_word_t owed_dates[$];
    stim_row_t  directed_rows[$];
    int         fault_count   = 0;
    int         results_seen  = 0;
    bit         sender_quiet  = 0;

    // Predictor state: 0-based month, day, signed year
    longint cal_month, cal_day, cal_year;
    bit     cal_wrap;
    int     month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    // Clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Fold a year into YEAR_WIDTH bits, flag the wrap if it moved
    function automatic longint fold_year(longint y);
        longint r;
        r = y & ((64'sd1 << gds_pkg::YEAR_WIDTH) - 1);
        if (r >= (64'sd1 << (gds_pkg::YEAR_WIDTH - 1)))
            r = r - (64'sd1 << gds_pkg::YEAR_WIDTH);
        if (r != y)
            cal_wrap = 1'b1;
        return r;
    endfunction

    function automatic int days_in(longint m, longint y);
        bit lp;
        lp = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        if (m == 1 && lp)
            return 29;
        return month_days[m];
    endfunction

    // Carry months into years, then walk the day into range month by month
    function automatic void settle_date();
        longint q, r;
        q = cal_month / 12;
        r = cal_month % 12;
        if (r < 0) begin
            r = r + 12;
            q = q - 1;
        end
        cal_month = r;
        cal_year  = fold_year(cal_year + q);
        while (cal_day <= 0) begin
            cal_month = cal_month - 1;
            if (cal_month < 0) begin
                cal_month = 11;
                cal_year  = fold_year(cal_year - 1);
            end
            cal_day = cal_day + days_in(cal_month, cal_year);
        end
        while (cal_day > days_in(cal_month, cal_year)) begin
            cal_day   = cal_day - days_in(cal_month, cal_year);
            cal_month = cal_month + 1;
            if (cal_month >= 12) begin
                cal_month = 0;
                cal_year  = fold_year(cal_year + 1);
            end
        end
    endfunction

    function automatic date_word_t step_calendar(stim_row_t w);
        date_word_t d;
        cal_wrap = 1'b0;
        case (w.act)
            gds_pkg::ACT_SET: begin
                cal_month = longint'($signed(w.month)) - 1;
                cal_day   = longint'($signed(w.day));
                cal_year  = fold_year(longint'($signed(w.year)));
                settle_date();
            end
            gds_pkg::ACT_INC: begin
                cal_day = cal_day + 1;
                settle_date();
            end
            gds_pkg::ACT_DEC: begin
                cal_day = cal_day - 1;
                settle_date();
            end
            default: ;
        endcase
        d.month = gds_pkg::MONTH_OUT_W'(cal_month + 1);
        d.day   = gds_pkg::DAY_OUT_W'(cal_day);
        d.year  = gds_pkg::YEAR_OUT_W'(cal_year);
        d.wrap  = cal_wrap;
        return d;
    endfunction

    function automatic void add_row(logic [gds_pkg::ACTION_W-1:0] act,
                                    logic [gds_pkg::LD_MONTH_W-1:0] mo,
                                    logic [gds_pkg::DAY_W-1:0] dy,
                                    logic [gds_pkg::LD_YEAR_W-1:0] yr,
                                    logic known, date_word_t want);
        stim_row_t r;
        r.act   = act;
        r.month = mo;
        r.day   = dy;
        r.year  = yr;
        r.known = known;
        r.want  = want;
        directed_rows.push_back(r);
    endfunction

    // Offer one word, wait for the handshake, record what it should produce
    task automatic send_word(stim_row_t w);
        date_word_t predicted;
        if (!sender_quiet) begin
            while ($urandom_range(0, 99) < 18) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.act;
        s_tdata  <= {3'b000, w.year, w.day, w.month};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predicted = step_calendar(w);
        owed_dates.push_back(w.known ? w.want : predicted);
        @(negedge aclk);
    endtask

    // Receiver: random back-pressure, one long hold-off, one idle-free stretch
    initial begin : result_sink
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 0;
        m_tready  = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_left == 0 && !held && results_seen >= 300) begin
                held      = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end else if (results_seen >= 700 && results_seen < 950) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 18);
            end
        end
    end

    // Compare every delivered word with the oldest owed date
    always @(posedge aclk) begin : result_check
        date_word_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.month = m_tdata[3:0];
            got.day   = m_tdata[8:4];
            got.year  = m_tdata[24:9];
            got.wrap  = m_tuser[0];
            results_seen = results_seen + 1;
            if (owed_dates.size() == 0) begin
                fault_count = fault_count + 1;
                $display("%0t: unexpected word, expected none, got %0d/%0d/%0d wrap %0b",
                         $time, got.month, got.day, $signed(got.year), got.wrap);
            end else begin
                want = owed_dates.pop_front();
                if (got !== want) begin
                    fault_count = fault_count + 1;
                    $display("%0t: mismatch, exp %0d/%0d/%0d wrap %0b, got %0d/%0d/%0d wrap %0b",
                             $time, want.month, want.day, $signed(want.year), want.wrap,
                             got.month, got.day, $signed(got.year), got.wrap);
                end
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        stim_row_t w;
        int issued, run_len, k;
        bit go_back;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        aresetn  = 1'b0;
        cal_month = 0;
        cal_day   = 1;
        cal_year  = 0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: reset date, year extremes, leap rules, carries, ignored fields
        add_row(gds_pkg::ACT_INC, 8'd0, 13'd0, 16'd0, 1'b1, '{4'd1, 5'd2, 16'd0, 1'b0});
        add_row(gds_pkg::ACT_DEC, 8'd0, 13'd0, 16'd0, 1'b1, '{4'd1, 5'd1, 16'd0, 1'b0});
        add_row(gds_pkg::ACT_DEC, 8'd0, 13'd0, 16'd0, 1'b1,
                '{4'd12, 5'd31, 16'hFFFF, 1'b0});
        add_row(gds_pkg::ACT_SET, 8'd12, 13'd31, 16'h7FFF, 1'b1,
                '{4'd12, 5'd31, 16'h7FFF, 1'b0});
        add_row(gds_pkg::ACT_INC, 8'd0, 13'd0, 16'd0, 1'b1, '{4'd1, 5'd1, 16'h8000, 1'b1});
        add_row(gds_pkg::ACT_DEC, 8'd0, 13'd0, 16'd0, 1'b1,
                '{4'd12, 5'd31, 16'h7FFF, 1'b1});
        add_row(gds_pkg::ACT_SET, 8'd1, 13'd1, 16'h8000, 1'b1,
                '{4'd1, 5'd1, 16'h8000, 1'b0});
        add_row(gds_pkg::ACT_DEC, 8'd0, 13'd0, 16'd0, 1'b1,
                '{4'd12, 5'd31, 16'h7FFF, 1'b1});
        add_row(gds_pkg::ACT_SET, 8'd2, 13'd29, 16'd2000, 1'b1,
                '{4'd2, 5'd29, 16'd2000, 1'b0});
        add_row(gds_pkg::ACT_SET, 8'd2, 13'd29, 16'd1900, 1'b0, '0);
        add_row(gds_pkg::ACT_SET, 8'd2, 13'd29, 16'hFE70, 1'b1,
                '{4'd2, 5'd29, 16'hFE70, 1'b0});
        add_row(gds_pkg::ACT_SET, 8'h7F, 13'h0FFF, 16'h7FFF, 1'b0, '0);
        add_row(gds_pkg::ACT_SET, 8'h80, 13'h1000, 16'h8000, 1'b0, '0);
        add_row(gds_pkg::ACT_SET, 8'd0, 13'd0, 16'd0, 1'b0, '0);
        add_row(gds_pkg::ACT_SET, 8'd13, 13'd1, 16'd5, 1'b1, '{4'd1, 5'd1, 16'd6, 1'b0});
        add_row(ACT_NONE, 8'hFF, 13'h1FFF, 16'hFFFF, 1'b0, '0);
        add_row(gds_pkg::ACT_INC, 8'h80, 13'h1000, 16'h8000, 1'b0, '0);
        add_row(gds_pkg::ACT_SET, 8'hFF, 13'd1, 16'd0, 1'b0, '0);
        add_row(gds_pkg::ACT_SET, 8'd2, 13'd28, 16'd2024, 1'b0, '0);
        add_row(gds_pkg::ACT_INC, 8'd0, 13'd0, 16'd0, 1'b0, '0);
        add_row(gds_pkg::ACT_INC, 8'd0, 13'd0, 16'd0, 1'b0, '0);
        add_row(gds_pkg::ACT_SET, 8'd3, 13'd0, 16'd2024, 1'b0, '0);
        add_row(gds_pkg::ACT_SET, 8'd1, 13'h0FFF, 16'd0, 1'b0, '0);
        add_row(gds_pkg::ACT_SET, 8'd1, 13'h1000, 16'd0, 1'b0, '0);
        add_row(gds_pkg::ACT_DEC, 8'd0, 13'd0, 16'd0, 1'b0, '0);

        @(negedge aclk);
        foreach (directed_rows[i])
            send_word(directed_rows[i]);

        // Random: a set, then a run of day steps or unused-code words with random ignored fields
        issued = 0;
        while (issued < RANDOM_ITEMS) begin
            w.known = 1'b0;
            w.want  = '0;
            w.act   = gds_pkg::ACT_SET;
            case ($urandom_range(0, 3))
                0: w.year = $urandom_range(0, 1) ? 16'(16'h7FFF - $urandom_range(0, 1))
                                                 : 16'(16'h8000 + $urandom_range(0, 1));
                1: w.year = 16'(100 * $urandom_range(0, 600) - 30000);
                default: w.year = 16'($urandom);
            endcase
            w.month = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(1, 12)) : 8'($urandom);
            case ($urandom_range(0, 19))
                0, 1, 2: w.day = 13'($urandom);
                3, 4, 5, 6, 7: w.day = 13'($urandom_range(0, 110)) - 13'd40;
                default: w.day = 13'($urandom_range(1, 31));
            endcase
            sender_quiet = (issued >= 700 && issued < 950);
            send_word(w);
            issued  = issued + 1;
            run_len = $urandom_range(1, 40);
            go_back = ($urandom_range(0, 1) != 0);
            for (k = 0; k < run_len; k++) begin
                if ($urandom_range(0, 19) == 0)
                    w.act = ACT_NONE;
                else if ($urandom_range(0, 5) == 0)
                    w.act = go_back ? gds_pkg::ACT_INC : gds_pkg::ACT_DEC;
                else
                    w.act = go_back ? gds_pkg::ACT_DEC : gds_pkg::ACT_INC;
                w.month = 8'($urandom);
                w.day   = 13'($urandom);
                w.year  = 16'($urandom);
                sender_quiet = (issued >= 700 && issued < 950);
                send_word(w);
                issued = issued + 1;
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then let any stray word show up
        while (owed_dates.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fault_count == 0 && owed_dates.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
